/* sv/csv_stream_tokenizer_macros.svh */
// Assertion helpers used by the checker of this block.
`ifndef CSV_STREAM_TOKENIZER_MACROS_SVH
`define CSV_STREAM_TOKENIZER_MACROS_SVH

// Same-cycle implication, sampled on the rising clock, off during reset.
`define CST_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on the rising clock, off during reset.
`define CST_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* sv/cst_pkg.sv */
package cst_pkg;

   localparam logic [7:0] CH_CR     = 8'd13;
   localparam logic [7:0] CH_LF     = 8'd10;
   localparam logic [7:0] CH_COMMA  = 8'd44;
   localparam logic [7:0] CH_DQUOTE = 8'd34;

   // Configuration register indexes
   localparam logic [1:0] CSR_FIELD_SEP  = 2'd0;
   localparam logic [1:0] CSR_RECORD_SEP = 2'd1;
   localparam logic [1:0] CSR_QUOTE      = 2'd2;

   typedef enum logic [1:0] {
      TK_DATA   = 2'd0,
      TK_FIELD  = 2'd1,
      TK_RECORD = 2'd2,
      TK_ERROR  = 2'd3
   } tok_kind_type;

   typedef enum logic [4:0] {
      PH_START      = 5'b00001,
      PH_UNQUOTED   = 5'b00010,
      PH_QUOTED     = 5'b00100,
      PH_QUOTE_SEEN = 5'b01000,
      PH_AFTER_CR   = 5'b10000
   } phase_type;

   typedef struct packed {
      tok_kind_type kind;
      logic [7:0]   data;
   } token_type;

   // Up to three tokens caused by one text byte, filled from index 0
   typedef struct packed {
      logic [1:0]      count;
      token_type [2:0] tok;
   } tok_grp_type;

   typedef struct packed {
      phase_type phase;
      logic      held_cr;
   } lex_state_type;

   typedef struct packed {
      logic [7:0] field_sep;
      logic [7:0] record_sep;
      logic [7:0] quote;
   } cfg_type;

   // Append one token to a group; data is zero for non-data tokens
   function automatic tok_grp_type grp_push(tok_grp_type g, tok_kind_type k,
                                            logic [7:0] b);
      tok_grp_type r;
      r = g;
      if (g.count != 2'd3) begin
         r.tok[g.count].kind = k;
         r.tok[g.count].data = (k == TK_DATA) ? b : 8'd0;
         r.count             = g.count + 2'd1;
      end
      return r;
   endfunction

endpackage

/* sv/csv_stream_tokenizer.sv */
// CSV tokenizer: one text byte per req transfer (with an end-of-text flag),
// zero to three tokens out per byte on rsp (data byte, field end, record
// end, unmatched-quote error), run_last set on each byte's final token.
// A byte passes the input register and the combinational lexer into the
// token group register before its first rsp token. While rsp_ready is
// high, bytes with at most one token stream at one per clock, and a byte
// with more holds the input side while the token register drains one token per
// cycle. Separator and quote bytes are set through csr and must be written
// by the user only while the block is idle; the block does not enforce it.
module csv_stream_tokenizer (
   input  logic       clock,
   input  logic       reset,
   // text bytes
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_in_byte,
   input  logic       req_end_of_text,
   // tokens
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [1:0] rsp_token_kind,
   output logic [7:0] rsp_token_byte,
   output logic       rsp_run_last,
   // configuration writes
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [1:0] csr_index,
   input  logic [7:0] csr_wdata
);
   import cst_pkg::*;

   logic          in_valid_ff, in_valid_in;
   logic [7:0]    in_byte_ff;
   logic          in_last_ff;
   lex_state_type state_ff, state_in;
   lex_state_type state_nxt;
   cfg_type       cfg_ff, cfg_in;
   tok_grp_type   grp;
   logic          ld_ready;
   logic          in_move;
   token_type     tok;

   // Configuration registers
   assign csr_ready = 1'b1;
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_FIELD_SEP:  cfg_in.field_sep  = csr_wdata;
            CSR_RECORD_SEP: cfg_in.record_sep = csr_wdata;
            CSR_QUOTE:      cfg_in.quote      = csr_wdata;
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   // Input register: refills as soon as its byte's tokens load into the token group register
   assign in_move     = in_valid_ff && ld_ready;
   assign req_ready   = !in_valid_ff || in_move;
   assign in_valid_in = req_valid ? 1'b1 : (in_valid_ff && !in_move);

   assign state_in = in_move ? state_nxt : state_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff       <= 1'b0;
         state_ff.phase    <= PH_START;
         state_ff.held_cr  <= 1'b0;
         cfg_ff.field_sep  <= CH_COMMA;
         cfg_ff.record_sep <= CH_LF;
         cfg_ff.quote      <= CH_DQUOTE;
      end else begin
         in_valid_ff <= in_valid_in;
         state_ff    <= state_in;
         cfg_ff      <= cfg_in;
      end
      if (req_valid && req_ready) begin
         in_byte_ff <= req_in_byte;
         in_last_ff <= req_end_of_text;
      end
   end

   cst_lexer u_lexer (
      .in_valid (in_valid_ff),
      .in_byte  (in_byte_ff),
      .in_last  (in_last_ff),
      .state    (state_ff),
      .cfg      (cfg_ff),
      .grp      (grp),
      .nxt      (state_nxt)
   );

   cst_drain u_drain (
      .clock     (clock),
      .reset     (reset),
      .ld_valid  (in_valid_ff),
      .ld_grp    (grp),
      .ld_ready  (ld_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_tok   (tok),
      .rsp_last  (rsp_run_last)
   );

   assign rsp_token_kind = 2'(tok.kind);
   assign rsp_token_byte = tok.data;

endmodule

/* sv/cst_lexer.sv */
module cst_lexer (
   input  logic                   in_valid,
   input  logic [7:0]             in_byte,
   input  logic                   in_last,
   input  cst_pkg::lex_state_type state,
   input  cst_pkg::cfg_type       cfg,
   output cst_pkg::tok_grp_type   grp,
   output cst_pkg::lex_state_type nxt
);
   import cst_pkg::*;

   typedef struct packed {
      tok_grp_type grp;
      phase_type   phase;
      logic        held_cr;
   } lex_work_type;

   // Byte that closes a field: separator, or the byte after a closing quote
   function automatic lex_work_type end_field(lex_work_type w, logic [7:0] c,
                                              logic last, cfg_type cf);
      lex_work_type r;
      r = w;
      if (c == cf.record_sep) begin
         r.grp   = grp_push(r.grp, TK_RECORD, 8'd0);
         r.phase = PH_START;
      end else if (c == CH_CR && cf.record_sep == CH_LF) begin
         if (last) begin
            r.grp   = grp_push(r.grp, TK_RECORD, 8'd0);
            r.phase = PH_START;
         end else begin
            r.phase = PH_AFTER_CR;
         end
      end else begin
         r.grp   = grp_push(r.grp, TK_FIELD, 8'd0);
         r.phase = PH_START;
         if (last) begin
            r.grp = grp_push(r.grp, TK_RECORD, 8'd0);
         end
      end
      return r;
   endfunction

   // Byte inside an unquoted field
   function automatic lex_work_type unquoted(lex_work_type w, logic [7:0] c,
                                             logic last, cfg_type cf);
      lex_work_type r;
      r = w;
      if (c == cf.field_sep || c == cf.record_sep) begin
         r = end_field(r, c, last, cf);
      end else if (cf.record_sep == CH_LF && c == CH_CR) begin
         if (last) begin
            r.grp   = grp_push(r.grp, TK_DATA, CH_CR);
            r.grp   = grp_push(r.grp, TK_RECORD, 8'd0);
            r.phase = PH_START;
         end else begin
            // hold the CR until the next byte shows whether LF follows
            r.held_cr = 1'b1;
            r.phase   = PH_UNQUOTED;
         end
      end else begin
         r.grp   = grp_push(r.grp, TK_DATA, c);
         r.phase = PH_UNQUOTED;
         if (last) begin
            r.grp   = grp_push(r.grp, TK_RECORD, 8'd0);
            r.phase = PH_START;
         end
      end
      return r;
   endfunction

   lex_work_type w;

   // One byte through the lexer: tokens plus next state
   always_comb begin
      w.grp     = '0;
      w.phase   = state.phase;
      w.held_cr = state.held_cr;
      unique case (state.phase)
         PH_UNQUOTED: begin
            if (state.held_cr && in_byte == CH_LF) begin
               w.held_cr = 1'b0;
               w.grp     = grp_push(w.grp, TK_RECORD, 8'd0);
               w.phase   = PH_START;
            end else begin
               if (state.held_cr) begin
                  w.held_cr = 1'b0;
                  w.grp     = grp_push(w.grp, TK_DATA, CH_CR);
               end
               w = unquoted(w, in_byte, in_last, cfg);
            end
         end
         PH_QUOTED: begin
            if (in_byte == cfg.quote) begin
               if (in_last) begin
                  w.grp   = grp_push(w.grp, TK_RECORD, 8'd0);
                  w.phase = PH_START;
               end else begin
                  w.phase = PH_QUOTE_SEEN;
               end
            end else if (in_last) begin
               w.grp   = grp_push(w.grp, TK_ERROR, 8'd0);
               w.phase = PH_START;
            end else begin
               w.grp = grp_push(w.grp, TK_DATA, in_byte);
            end
         end
         PH_QUOTE_SEEN: begin
            if (in_byte == cfg.quote) begin
               if (in_last) begin
                  w.grp   = grp_push(w.grp, TK_ERROR, 8'd0);
                  w.phase = PH_START;
               end else begin
                  w.grp   = grp_push(w.grp, TK_DATA, in_byte);
                  w.phase = PH_QUOTED;
               end
            end else begin
               w = end_field(w, in_byte, in_last, cfg);
            end
         end
         PH_AFTER_CR: begin
            w.phase = PH_START;
            if (in_byte == CH_LF) begin
               w.grp = grp_push(w.grp, TK_RECORD, 8'd0);
            end else begin
               w.grp = grp_push(w.grp, TK_FIELD, 8'd0);
               if (in_last) begin
                  w.grp = grp_push(w.grp, TK_RECORD, 8'd0);
               end
            end
         end
         default: begin
            // field start, and any unused phase code
            w.held_cr = 1'b0;
            if (in_byte == cfg.quote) begin
               if (in_last) begin
                  w.grp   = grp_push(w.grp, TK_ERROR, 8'd0);
                  w.phase = PH_START;
               end else begin
                  w.phase = PH_QUOTED;
               end
            end else begin
               w = unquoted(w, in_byte, in_last, cfg);
            end
         end
      endcase
      // end of text: the next byte begins a new text
      if (in_last) begin
         w.phase   = PH_START;
         w.held_cr = 1'b0;
      end
   end

   // An empty input slot yields no tokens and keeps the state
   assign grp         = in_valid ? w.grp : '0;
   assign nxt.phase   = in_valid ? w.phase : state.phase;
   assign nxt.held_cr = in_valid ? w.held_cr : state.held_cr;

endmodule

/* sv/cst_drain.sv */
module cst_drain (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 ld_valid,
   input  cst_pkg::tok_grp_type ld_grp,
   output logic                 ld_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output cst_pkg::token_type   rsp_tok,
   output logic                 rsp_last
);
   import cst_pkg::*;

   tok_grp_type grp_ff, grp_in;
   logic [1:0]  idx_ff, idx_in;
   logic        valid_ff, valid_in;
   logic        at_last;

   assign at_last  = (idx_ff == 2'(grp_ff.count - 2'd1));
   // A new group may load once the current one hands off its final token
   assign ld_ready = !valid_ff || (rsp_ready && at_last);

   // Group register and token pointer
   always_comb begin
      grp_in   = grp_ff;
      idx_in   = idx_ff;
      valid_in = valid_ff;
      if (ld_valid && ld_ready) begin
         grp_in   = ld_grp;
         idx_in   = 2'd0;
         valid_in = (ld_grp.count != 2'd0);
      end else if (valid_ff && rsp_ready) begin
         // final token leaves with nothing loading behind it
         if (at_last) begin
            valid_in = 1'b0;
         end else begin
            idx_in = idx_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= 2'd0;
      end else begin
         valid_ff <= valid_in;
         idx_ff   <= idx_in;
      end
      grp_ff <= grp_in;
   end

   assign rsp_valid = valid_ff;
   assign rsp_tok   = grp_ff.tok[idx_ff];
   assign rsp_last  = at_last;

endmodule

/* sv/cst_checker.sv */
`include "csv_stream_tokenizer_macros.svh"

module cst_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [1:0] rsp_token_kind,
   input logic [7:0] rsp_token_byte,
   input logic       rsp_run_last
);
   import cst_pkg::*;

   // stalled token holds
   `CST_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_token_kind) && $stable(rsp_token_byte) && $stable(rsp_run_last), "rsp token changed while stalled")

   // only data tokens carry a byte
   `CST_ASSERT_NOW(a_byte_zero, rsp_valid && rsp_token_kind != TK_DATA, rsp_token_byte == 8'd0, "non-data token with nonzero byte")

   // record end and error always close a byte's tokens
   `CST_ASSERT_NOW(a_rec_last, rsp_valid && rsp_token_kind == TK_RECORD, rsp_run_last, "record end not last token of its byte")
   `CST_ASSERT_NOW(a_err_last, rsp_valid && rsp_token_kind == TK_ERROR, rsp_run_last, "error not last token of its byte")

   // a field end that is not last is always followed at once by a record end
   `CST_ASSERT_NEXT(a_field_rec, rsp_valid && rsp_ready && rsp_token_kind == TK_FIELD && !rsp_run_last, rsp_valid && rsp_token_kind == TK_RECORD, "field end not followed by record end")

endmodule

bind csv_stream_tokenizer cst_checker u_cst_checker (.*);
